// ===== sv/aedr_pkg.sv =====
// ----------------------------------------------------------------------------
// aedr_pkg: shared types, constants and microprogram for the envelope block
// Holds the phase and register codes, the control word layout and the
// read-only microprogram that sequences one envelope word per tick.
// ----------------------------------------------------------------------------
package aedr_pkg;

  // Sample index width and the fixed field widths
  localparam int INDEX_BITS  = 24;
  localparam int LEVEL_W     = 32;
  localparam int FACTOR_W    = 16;
  localparam int OUT_W       = 16;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int PROD_W      = LEVEL_W + FACTOR_W;
  localparam int DIV_CNT_W   = $clog2(LEVEL_W + 1);
  localparam int STEP_W      = 5;

  // 1.0 in unsigned Q1.31
  localparam logic [LEVEL_W-1:0] ONE_Q31 = {1'b1, {(LEVEL_W-1){1'b0}}};

  // Configuration register reset values
  localparam logic [INDEX_BITS-1:0] NOTE_RESET   = INDEX_BITS'(1);
  localparam logic [FACTOR_W-1:0]   FACTOR_RESET = {FACTOR_W{1'b1}};

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ATTACK  = 2'd1,
    PH_DECAY   = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NOTE_SAMPLES = 2'd0,
    REG_ATTACK       = 2'd1,
    REG_DECAY_END    = 2'd2,
    REG_DECAY_FACTOR = 2'd3
  } cfg_reg_t;

  // Datapath actions, one per control word
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_IDX_ZERO,
    OP_IDX_INC,
    OP_SET_IDLE,
    OP_ATTACK_START,
    OP_STEP_LOAD,
    OP_DECAY_START,
    OP_SET_ONE,
    OP_RELEASE_START,
    OP_ACC_ADD,
    OP_MUL,
    OP_ACC_PROD,
    OP_ACC_SUB,
    OP_EMIT
  } op_t;

  // Jump conditions; a true condition loads the target, else the counter advances
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_NOT_RESTART,
    C_N_NONZERO,
    C_A_ZERO,
    C_DIV_BUSY,
    C_IDLE,
    C_KEND,
    C_PH_DECAY,
    C_PH_RELEASE,
    C_K_GE_A,
    C_K_GE_D,
    C_K_LT_D,
    C_OUT_FULL
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  // Microprogram addresses
  localparam step_t S_FETCH     = 5'd0;
  localparam step_t S_DISPATCH  = 5'd1;
  localparam step_t S_RESTART   = 5'd2;
  localparam step_t S_GO_IDLE   = 5'd3;
  localparam step_t S_BEGIN     = 5'd4;
  localparam step_t S_ATK_DIV   = 5'd5;
  localparam step_t S_ATK_WAIT  = 5'd6;
  localparam step_t S_ATK_LOAD  = 5'd7;
  localparam step_t S_ADVANCE   = 5'd8;
  localparam step_t S_INC       = 5'd9;
  localparam step_t S_END_CHK   = 5'd10;
  localparam step_t S_SEL_DECAY = 5'd11;
  localparam step_t S_SEL_REL   = 5'd12;
  localparam step_t S_ATK_CHK   = 5'd13;
  localparam step_t S_ATK_ADD   = 5'd14;
  localparam step_t S_DEC_MUL   = 5'd15;
  localparam step_t S_DEC_ACC   = 5'd16;
  localparam step_t S_DEC_END   = 5'd17;
  localparam step_t S_REL_SUB   = 5'd18;
  localparam step_t S_BDR       = 5'd19;
  localparam step_t S_DEC_START = 5'd20;
  localparam step_t S_REL_DIV   = 5'd21;
  localparam step_t S_REL_WAIT  = 5'd22;
  localparam step_t S_REL_LOAD  = 5'd23;
  localparam step_t S_OUT_WAIT  = 5'd24;
  localparam step_t S_EMIT      = 5'd25;

  // Control store: one word per step
  function automatic ctrl_word_t ucode(input step_t step);
    ctrl_word_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: S_FETCH};
    unique case (step)
      // wait for a tick, latch restart
      S_FETCH:     w = '{op: OP_LATCH,        cond: C_NO_INPUT,    target: S_FETCH};
      S_DISPATCH:  w = '{op: OP_NONE,         cond: C_NOT_RESTART, target: S_ADVANCE};
      // new note
      S_RESTART:   w = '{op: OP_IDX_ZERO,     cond: C_N_NONZERO,   target: S_BEGIN};
      S_GO_IDLE:   w = '{op: OP_SET_IDLE,     cond: C_ALWAYS,      target: S_OUT_WAIT};
      S_BEGIN:     w = '{op: OP_NONE,         cond: C_A_ZERO,      target: S_BDR};
      S_ATK_DIV:   w = '{op: OP_ATTACK_START, cond: C_NEVER,       target: S_FETCH};
      S_ATK_WAIT:  w = '{op: OP_NONE,         cond: C_DIV_BUSY,    target: S_ATK_WAIT};
      S_ATK_LOAD:  w = '{op: OP_STEP_LOAD,    cond: C_ALWAYS,      target: S_OUT_WAIT};
      // next sample of a running note
      S_ADVANCE:   w = '{op: OP_NONE,         cond: C_IDLE,        target: S_OUT_WAIT};
      S_INC:       w = '{op: OP_IDX_INC,      cond: C_NEVER,       target: S_FETCH};
      S_END_CHK:   w = '{op: OP_NONE,         cond: C_KEND,        target: S_GO_IDLE};
      S_SEL_DECAY: w = '{op: OP_NONE,         cond: C_PH_DECAY,    target: S_DEC_MUL};
      S_SEL_REL:   w = '{op: OP_NONE,         cond: C_PH_RELEASE,  target: S_REL_SUB};
      S_ATK_CHK:   w = '{op: OP_NONE,         cond: C_K_GE_A,      target: S_BDR};
      S_ATK_ADD:   w = '{op: OP_ACC_ADD,      cond: C_ALWAYS,      target: S_OUT_WAIT};
      S_DEC_MUL:   w = '{op: OP_MUL,          cond: C_NEVER,       target: S_FETCH};
      S_DEC_ACC:   w = '{op: OP_ACC_PROD,     cond: C_K_LT_D,      target: S_OUT_WAIT};
      S_DEC_END:   w = '{op: OP_NONE,         cond: C_ALWAYS,      target: S_REL_DIV};
      S_REL_SUB:   w = '{op: OP_ACC_SUB,      cond: C_ALWAYS,      target: S_OUT_WAIT};
      // attack done: enter decay, or release straight from full scale
      S_BDR:       w = '{op: OP_SET_ONE,      cond: C_K_GE_D,      target: S_REL_DIV};
      S_DEC_START: w = '{op: OP_DECAY_START,  cond: C_ALWAYS,      target: S_OUT_WAIT};
      S_REL_DIV:   w = '{op: OP_RELEASE_START, cond: C_NEVER,      target: S_FETCH};
      S_REL_WAIT:  w = '{op: OP_NONE,         cond: C_DIV_BUSY,    target: S_REL_WAIT};
      S_REL_LOAD:  w = '{op: OP_STEP_LOAD,    cond: C_ALWAYS,      target: S_OUT_WAIT};
      // hand the word to the output register
      S_OUT_WAIT:  w = '{op: OP_NONE,         cond: C_OUT_FULL,    target: S_OUT_WAIT};
      S_EMIT:      w = '{op: OP_EMIT,         cond: C_ALWAYS,      target: S_FETCH};
      default:     w = '{op: OP_NONE,         cond: C_ALWAYS,      target: S_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/attack_exp_decay_release_envelope.sv =====
// ----------------------------------------------------------------------------
// attack_exp_decay_release_envelope: microcoded attack/decay/release envelope
// Sequencer walks a small control store; a plain datapath holds the sample
// index, the Q1.31 level, the ramp step, a 32x16 multiplier and a
// bit-serial divider for the ramp steps.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, restart): one tick per word. restart=1
//   starts a new note at sample 0, restart=0 advances one sample.
//   Output channel (out_valid/out_ready): one word per tick with level
//   (Q1.15), active and last_sample. Outside a note the word is all zero.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   index 0 note length, 1 attack length, 2 decay end, 3 decay factor.
//   Write only between ticks, once the previous word has come out.
// Sequencing:
//   A tick that starts the attack or the release waits on the divider,
//   which retires one quotient bit per cycle over 32 bits. Ticks are
//   handled one at a time; in_ready is high only at the fetch step, to which
//   the sequencer returns after loading the previous word into the output
//   register.
// Reset:
//   Synchronous, active high. Clears the sequencer, the envelope state and
//   the output valid flag, and loads the register defaults (note length 1,
//   decay factor 0xFFFF).
// Stall:
//   The finished word sits in the output register; the next tick is accepted
//   and computed meanwhile, and the sequencer waits before emitting it.
// ----------------------------------------------------------------------------
module attack_exp_decay_release_envelope
  import aedr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // tick channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   restart,
  // envelope channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_W-1:0]       level,
  output logic                   active,
  output logic                   last_sample,
  // configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers
  logic [INDEX_BITS-1:0] note_samples;
  logic [INDEX_BITS-1:0] attack_len;
  logic [INDEX_BITS-1:0] decay_end_sample;
  logic [FACTOR_W-1:0]   decay_factor;

  // Sequencer
  step_t      pc;
  ctrl_word_t cw;
  logic       jump;
  logic       restart_q;

  // Envelope state
  logic [INDEX_BITS-1:0] sample_index;
  logic [LEVEL_W-1:0]    level_accum;
  logic [LEVEL_W-1:0]    ramp_step;
  phase_t                phase;
  logic [PROD_W-1:0]     prod;

  // Divider
  logic                   div_busy;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [LEVEL_W-1:0]     div_quo;
  logic [INDEX_BITS-1:0]  div_rem;
  logic [INDEX_BITS-1:0]  div_den;
  logic [INDEX_BITS-1:0]  div_den_in;
  logic [INDEX_BITS:0]    div_shift;
  logic [INDEX_BITS+1:0]  div_trial;

  // Clamped bounds
  logic [INDEX_BITS-1:0] attack_end;
  logic [INDEX_BITS-1:0] decay_end;

  assign cfg_ready = 1'b1;
  assign in_ready  = (pc == S_FETCH);

  // Clamp the phase ends to the note length
  assign attack_end = (attack_len > note_samples) ? note_samples : attack_len;
  assign decay_end  = (decay_end_sample > note_samples) ? note_samples : decay_end_sample;

  // Fetch the control word
  assign cw = ucode(pc);

  // Evaluate the jump condition
  always_comb begin
    unique case (cw.cond)
      C_NEVER:       jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_NO_INPUT:    jump = !in_valid;
      C_NOT_RESTART: jump = !restart_q;
      C_N_NONZERO:   jump = (note_samples != '0);
      C_A_ZERO:      jump = (attack_end == '0);
      C_DIV_BUSY:    jump = div_busy;
      C_IDLE:        jump = (phase == PH_IDLE);
      C_KEND:        jump = (sample_index >= note_samples) || (sample_index == '0);
      C_PH_DECAY:    jump = (phase == PH_DECAY);
      C_PH_RELEASE:  jump = (phase == PH_RELEASE);
      C_K_GE_A:      jump = (sample_index >= attack_end);
      C_K_GE_D:      jump = (sample_index >= decay_end);
      C_K_LT_D:      jump = (sample_index < decay_end);
      C_OUT_FULL:    jump = out_valid && !out_ready;
      default:       jump = 1'b0;
    endcase
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_FETCH;
    end else if (jump) begin
      pc <= cw.target;
    end else begin
      pc <= pc + step_t'(1);
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      note_samples     <= NOTE_RESET;
      attack_len       <= '0;
      decay_end_sample <= '0;
      decay_factor     <= FACTOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NOTE_SAMPLES: note_samples     <= cfg_data[INDEX_BITS-1:0];
        REG_ATTACK:       attack_len       <= cfg_data[INDEX_BITS-1:0];
        REG_DECAY_END:    decay_end_sample <= cfg_data[INDEX_BITS-1:0];
        REG_DECAY_FACTOR: decay_factor     <= cfg_data[FACTOR_W-1:0];
        default:          note_samples     <= note_samples;
      endcase
    end
  end

  // Divisor for the step being started
  assign div_den_in = (cw.op == OP_ATTACK_START) ? attack_end : (note_samples - sample_index);

  // Envelope datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      restart_q    <= 1'b0;
      sample_index <= '0;
      level_accum  <= '0;
      ramp_step    <= '0;
      phase        <= PH_IDLE;
    end else begin
      unique case (cw.op)
        OP_LATCH: begin
          if (in_valid) restart_q <= restart;
        end
        OP_IDX_ZERO:  sample_index <= '0;
        OP_IDX_INC:   sample_index <= sample_index + INDEX_BITS'(1);
        OP_SET_IDLE:  phase <= PH_IDLE;
        OP_ATTACK_START: begin
          phase       <= PH_ATTACK;
          level_accum <= '0;
        end
        OP_STEP_LOAD: ramp_step <= div_quo;
        OP_DECAY_START: begin
          phase     <= PH_DECAY;
          ramp_step <= '0;
        end
        OP_SET_ONE:       level_accum <= ONE_Q31;
        OP_RELEASE_START: phase <= PH_RELEASE;
        OP_ACC_ADD:       level_accum <= level_accum + ramp_step;
        OP_ACC_PROD:      level_accum <= prod[PROD_W-1:FACTOR_W];
        OP_ACC_SUB: begin
          level_accum <= (level_accum >= ramp_step) ? level_accum - ramp_step : '0;
        end
        OP_EMIT: begin
          if (sample_index >= note_samples) phase <= PH_IDLE;
        end
        default: phase <= phase;
      endcase
    end
  end

  // Scale the level by the decay factor
  always_ff @(posedge clk) begin
    if (cw.op == OP_MUL) begin
      prod <= {{FACTOR_W{1'b0}}, level_accum} * {{LEVEL_W{1'b0}}, decay_factor};
    end
  end

  // Restoring divider, one quotient bit per cycle
  assign div_shift = {div_rem, div_quo[LEVEL_W-1]};
  assign div_trial = {1'b0, div_shift} - {2'b00, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (cw.op == OP_ATTACK_START || cw.op == OP_RELEASE_START) begin
      div_busy <= 1'b1;
      div_cnt  <= DIV_CNT_W'(LEVEL_W);
    end else if (div_busy) begin
      div_cnt  <= div_cnt - DIV_CNT_W'(1);
      if (div_cnt == DIV_CNT_W'(1)) div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == OP_ATTACK_START || cw.op == OP_RELEASE_START) begin
      div_quo <= (cw.op == OP_ATTACK_START) ? ONE_Q31 : level_accum;
      div_rem <= '0;
      div_den <= div_den_in;
    end else if (div_busy) begin
      if (!div_trial[INDEX_BITS+1]) begin
        div_rem <= div_trial[INDEX_BITS-1:0];
        div_quo <= {div_quo[LEVEL_W-2:0], 1'b1};
      end else begin
        div_rem <= div_shift[INDEX_BITS-1:0];
        div_quo <= {div_quo[LEVEL_W-2:0], 1'b0};
      end
    end
  end

  // Output register: load at emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == OP_EMIT) begin
      if (phase == PH_IDLE || sample_index >= note_samples) begin
        level       <= '0;
        active      <= 1'b0;
        last_sample <= 1'b0;
      end else begin
        level       <= level_accum[LEVEL_W-1:LEVEL_W-OUT_W];
        active      <= 1'b1;
        last_sample <= (sample_index == note_samples - INDEX_BITS'(1));
      end
    end
  end

  // Checks
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_EMIT) |-> !out_valid)
    else $error("emit while output register still full");

  a_fetch_div_idle: assert property (@(posedge clk) disable iff (rst)
    (pc == S_FETCH) |-> !div_busy)
    else $error("divider busy at fetch");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_ATTACK_START || cw.op == OP_RELEASE_START) |-> (div_den_in != '0))
    else $error("ramp division by zero");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (pc == S_DISPATCH))
    else $error("accepted tick not dispatched");

  a_inactive_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !active) |-> (level == '0 && !last_sample))
    else $error("inactive word carries data");

endmodule
